// ===== hdl/mcat_pkg.sv =====
// ----------------------------------------------------------------------------
// mcat_pkg: shared types and constants of the admission test block
// Table entry layout, action codes, iteration bounds and arithmetic width.
// ----------------------------------------------------------------------------
package mcat_pkg;

  localparam int unsigned DEF_TABLE_SLOTS = 16;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned CRIT_W          = 8;
  localparam int unsigned VAL_W           = 64;
  localparam int unsigned ITER_LIMIT      = 256;
  localparam int unsigned ITER_W          = 9;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_ADMIT = 2'd2;

  typedef struct packed {
    logic [CRIT_W-1:0] level;
    logic [TIME_W-1:0] rm_exec;
    logic [TIME_W-1:0] nominal;
    logic [TIME_W-1:0] exectime;
    logic [TIME_W-1:0] period;
  } entry_t;

endpackage

// ===== hdl/mcat_ram.sv =====
// ----------------------------------------------------------------------------
// mcat_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mcat_term.sv =====
// ----------------------------------------------------------------------------
// mcat_term: interference term unit
// Computes ceil(x / p) * v modulo 2^64, with p of zero taken as one.
// Restoring division one bit a cycle, then a bit-serial multiply.
// ----------------------------------------------------------------------------
module mcat_term (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mcat_pkg::VAL_W-1:0]  x_i,
  input  logic [mcat_pkg::TIME_W-1:0] p_i,
  input  logic [mcat_pkg::VAL_W-1:0]  v_i,
  output logic                       done_o,
  output logic [mcat_pkg::VAL_W-1:0]  result_o
);

  typedef enum logic [1:0] {T_IDLE, T_DIV, T_MUL} tstate_e;

  tstate_e                        state_q;
  logic [5:0]                     cnt_q;
  logic [mcat_pkg::VAL_W-1:0]     quo_q;
  logic [mcat_pkg::TIME_W-1:0]    rem_q;
  logic [mcat_pkg::TIME_W-1:0]    div_q;
  logic [mcat_pkg::VAL_W-1:0]     mcand_q;
  logic [mcat_pkg::VAL_W-1:0]     mplier_q;
  logic [mcat_pkg::VAL_W-1:0]     prod_q;
  logic [mcat_pkg::TIME_W:0]      trial;
  logic                           fits;

  assign trial = {rem_q, quo_q[mcat_pkg::VAL_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= (state_q == T_MUL) && (cnt_q == 6'd63);
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            quo_q    <= x_i;
            rem_q    <= '0;
            div_q    <= (p_i == '0) ? mcat_pkg::TIME_W'(1) : p_i;
            mplier_q <= v_i;
            prod_q   <= '0;
            cnt_q    <= '0;
            state_q  <= T_DIV;
          end
        end
        T_DIV: begin
          rem_q <= fits ? mcat_pkg::TIME_W'(trial - {1'b0, div_q})
                        : mcat_pkg::TIME_W'(trial);
          quo_q <= {quo_q[mcat_pkg::VAL_W-2:0], fits};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= T_MUL;
          end
        end
        T_MUL: begin
          if (mplier_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q  <= {mcand_q[mcat_pkg::VAL_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[mcat_pkg::VAL_W-1:1]};
          cnt_q    <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q  <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
      // load the rounded quotient as multiplicand on the last divide step
      if (state_q == T_DIV && cnt_q == 6'd63) begin
        mcand_q <= {quo_q[mcat_pkg::VAL_W-2:0], fits}
                 + mcat_pkg::VAL_W'(((fits ? mcat_pkg::TIME_W'(trial - {1'b0, div_q})
                                           : mcat_pkg::TIME_W'(trial)) != '0));
      end
    end
  end

  assign result_o = prod_q;

endmodule

// ===== hdl/mixed_criticality_admission_test.sv =====
// ----------------------------------------------------------------------------
// mixed_criticality_admission_test: zero-slack admission test over a reserve table
// Holds a table of task reserves in a RAM and runs the zero-slack response
// time analysis for a candidate reserve.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel s_axis_*: tuser carries the action (write slot, clear slot,
//  run admission test), tdata the slot, skip flag and reserve fields.
//  Write and clear items give no result. An admit item gives one result
//  item on m_axis_*: admitted flag, final zero-slack instant and granted
//  rate-monotonic budget.
//  The block works on one item at a time; s_axis_tready is high only while
//  the sequencer is idle. An admit item walks the table once per response
//  iteration and at most twice per zero-slack round; every selected slot
//  costs one pass of the term unit (a restoring divide, then a multiply),
//  an unselected slot only the RAM read. The work is bounded by 256
//  zero-slack rounds of at most 256 response rounds each.
//  Reset empties the table at once (occupied flags in flip-flops) and
//  idles the sequencer; no clearing pass is needed.
//  A result holds in the output register while m_axis_tready is low; the
//  block still takes write and clear items then, and a later admit item
//  waits at its end until the held result is taken.
// ----------------------------------------------------------------------------
module mixed_criticality_admission_test #(
  parameter int unsigned TABLE_SLOTS = mcat_pkg::DEF_TABLE_SLOTS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: slot[3:0], self_in_table[4], period[52:5], exec_time[100:53],
  //        nominal_time[148:101], rm_time[196:149],
  //        criticality[204:197], zero fill above
  input  logic [207:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: admitted[0], zero_slack_instant[48:1], rm_budget_ns[96:49], zero fill
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned SW  = $clog2(TABLE_SLOTS);
  localparam int unsigned VW  = mcat_pkg::VAL_W;
  localparam int unsigned TW  = mcat_pkg::TIME_W;
  localparam int unsigned EW  = $bits(mcat_pkg::entry_t);
  localparam int unsigned IW  = mcat_pkg::ITER_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OUT_CHECK, ST_RTA_CHECK, ST_AFTER, ST_RD, ST_CLS, ST_WAIT,
    ST_SCAN_END, ST_ZS_EVAL, ST_PUSH_EVAL, ST_ZS_FIN, ST_DONE
  } state_e;

  typedef enum logic [1:0] {SK_RTA, SK_RMZ, SK_RMP} scan_e;

  // input field unpacking
  logic [3:0]                  in_slot;
  logic                        in_self;
  mcat_pkg::entry_t            in_entry;
  logic                        slot_ok;

  assign in_slot          = s_axis_tdata[3:0];
  assign in_self          = s_axis_tdata[4];
  assign in_entry.period  = s_axis_tdata[52:5];
  assign in_entry.exectime = s_axis_tdata[100:53];
  assign in_entry.nominal = s_axis_tdata[148:101];
  assign in_entry.rm_exec = s_axis_tdata[196:149];
  assign in_entry.level   = s_axis_tdata[204:197];
  assign slot_ok          = 32'(in_slot) < TABLE_SLOTS;

  state_e               state_q;
  scan_e                kind_q;
  logic [TABLE_SLOTS-1:0] occ_q;
  logic [SW-1:0]        idx_q;
  logic [IW-1:0]        zs_n_q;
  logic [IW-1:0]        rta_n_q;
  logic                 first_q;
  logic [TW-1:0]        cp_q;
  logic [TW-1:0]        cexec_q;
  logic [mcat_pkg::CRIT_W-1:0] ccrit_q;
  logic [3:0]           skip_q;
  logic                 skip_v_q;
  logic [VW-1:0]        crm_q;
  logic [VW-1:0]        resp_q;
  logic [VW-1:0]        prev_q;
  logic [VW-1:0]        base_q;
  logic [VW-1:0]        z_q;
  logic [VW-1:0]        prev_z_q;
  logic [VW-1:0]        x_q;
  logic [VW-1:0]        acc_q;
  logic [VW-1:0]        push_q;
  logic [VW-1:0]        slack_q;

  logic                 accept;
  logic                 ram_we;
  mcat_pkg::entry_t     rd_entry;
  logic [EW-1:0]        rd_raw;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign ram_we = accept && s_axis_tuser == mcat_pkg::ACT_WRITE && slot_ok;

  mcat_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (SW'(in_slot)),
    .wdata_i (in_entry),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );
  assign rd_entry = mcat_pkg::entry_t'(rd_raw);

  // slot classification against the candidate
  logic          sel_live, sel_hp, sel_hc, sel_sc, sel_ge;
  logic          sel_use;
  logic [VW-1:0] sel_val;

  assign sel_live = occ_q[idx_q] && !(skip_v_q && 32'(idx_q) == 32'(skip_q));
  assign sel_hp   = cp_q >= rd_entry.period;
  assign sel_hc   = ccrit_q < rd_entry.level;
  assign sel_sc   = ccrit_q == rd_entry.level;
  assign sel_ge   = ccrit_q >= rd_entry.level;

  always_comb begin
    sel_use = 1'b0;
    sel_val = VW'(rd_entry.exectime);
    if (sel_live) begin
      if (kind_q == SK_RTA) begin
        if (sel_hc) begin
          sel_use = 1'b1;
          sel_val = sel_hp ? VW'(rd_entry.nominal)
                           : VW'(rd_entry.nominal) - VW'(rd_entry.rm_exec);
        end else if (sel_hp && sel_sc) begin
          sel_use = 1'b1;
        end
      end else if (sel_hp) begin
        sel_use = 1'b1;
        if (sel_hc) begin
          sel_val = VW'(rd_entry.nominal);
        end else if (!sel_ge) begin
          sel_use = 1'b0;
        end
      end
    end
  end

  logic          term_start;
  logic          term_done;
  logic [VW-1:0] term_res;

  assign term_start = (state_q == ST_CLS) && sel_use;

  mcat_term u_term (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (term_start),
    .x_i      (x_q),
    .p_i      (rd_entry.period),
    .v_i      (sel_val),
    .done_o   (term_done),
    .result_o (term_res)
  );

  // loop conditions
  logic          outer_go, rta_go, last_idx;
  logic [VW-1:0] cp64, sum_ir, push_w, zp_w;

  assign cp64     = VW'(cp_q);
  assign outer_go = cp64 >= resp_q && z_q > prev_z_q && 32'(zs_n_q) < mcat_pkg::ITER_LIMIT;
  assign rta_go   = first_q || (resp_q > prev_q && resp_q <= cp64);
  assign last_idx = idx_q == SW'(TABLE_SLOTS - 1);
  assign sum_ir   = acc_q + crm_q;
  assign push_w   = resp_q - VW'(cexec_q) + crm_q;
  assign zp_w     = z_q + push_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      occ_q         <= '0;
      m_axis_tvalid <= 1'b0;
      idx_q         <= '0;
      kind_q        <= SK_RTA;
    end else begin
      // raise the result on the done step, drop it once taken
      if (state_q == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser)
              mcat_pkg::ACT_WRITE: begin
                if (slot_ok) occ_q[SW'(in_slot)] <= 1'b1;
              end
              mcat_pkg::ACT_CLEAR: begin
                if (slot_ok) occ_q[SW'(in_slot)] <= 1'b0;
              end
              mcat_pkg::ACT_ADMIT: begin
                cp_q     <= in_entry.period;
                cexec_q  <= in_entry.exectime;
                ccrit_q  <= in_entry.level;
                skip_q   <= in_slot;
                skip_v_q <= in_self;
                crm_q    <= '0;
                resp_q   <= '0;
                z_q      <= VW'(1);
                prev_z_q <= '0;
                zs_n_q   <= '0;
                state_q  <= ST_OUT_CHECK;
              end
              default: ;
            endcase
          end
        end
        ST_OUT_CHECK: begin
          if (outer_go) begin
            zs_n_q   <= zs_n_q + IW'(1);
            prev_z_q <= z_q;
            base_q   <= VW'(cexec_q) - crm_q;
            resp_q   <= VW'(cexec_q) - crm_q;
            prev_q   <= '0;
            first_q  <= 1'b1;
            rta_n_q  <= '0;
            state_q  <= ST_RTA_CHECK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_RTA_CHECK: begin
          if (rta_go) begin
            if (32'(rta_n_q) >= mcat_pkg::ITER_LIMIT) begin
              resp_q  <= cp64 + VW'(1);
              state_q <= ST_AFTER;
            end else begin
              rta_n_q <= rta_n_q + IW'(1);
              first_q <= 1'b0;
              prev_q  <= resp_q;
              x_q     <= resp_q;
              acc_q   <= base_q;
              idx_q   <= '0;
              kind_q  <= SK_RTA;
              state_q <= ST_RD;
            end
          end else begin
            state_q <= ST_AFTER;
          end
        end
        ST_AFTER: begin
          if (cp64 >= resp_q) begin
            z_q     <= cp64 - resp_q;
            x_q     <= cp64 - resp_q;
            acc_q   <= '0;
            idx_q   <= '0;
            kind_q  <= SK_RMZ;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_OUT_CHECK;
          end
        end
        ST_RD: state_q <= ST_CLS;
        ST_CLS: begin
          if (sel_use) begin
            state_q <= ST_WAIT;
          end else if (last_idx) begin
            state_q <= ST_SCAN_END;
          end else begin
            idx_q   <= idx_q + SW'(1);
            state_q <= ST_RD;
          end
        end
        ST_WAIT: begin
          if (term_done) begin
            acc_q <= acc_q + term_res;
            if (last_idx) begin
              state_q <= ST_SCAN_END;
            end else begin
              idx_q   <= idx_q + SW'(1);
              state_q <= ST_RD;
            end
          end
        end
        ST_SCAN_END: begin
          unique case (kind_q)
            SK_RTA: begin
              resp_q  <= acc_q;
              state_q <= ST_RTA_CHECK;
            end
            SK_RMZ:  state_q <= ST_ZS_EVAL;
            default: state_q <= ST_PUSH_EVAL;
          endcase
        end
        ST_ZS_EVAL: begin
          if (z_q > sum_ir) begin
            slack_q <= z_q - sum_ir;
            state_q <= ST_ZS_FIN;
          end else if (z_q == sum_ir && zp_w <= cp64) begin
            push_q  <= push_w;
            x_q     <= zp_w;
            acc_q   <= '0;
            idx_q   <= '0;
            kind_q  <= SK_RMP;
            state_q <= ST_RD;
          end else begin
            slack_q <= '0;
            state_q <= ST_ZS_FIN;
          end
        end
        ST_PUSH_EVAL: begin
          // grow Z only when the pushed window opens slack
          if (acc_q <= push_q) begin
            z_q     <= x_q;
            slack_q <= x_q - acc_q - crm_q;
          end else begin
            slack_q <= '0;
          end
          state_q <= ST_ZS_FIN;
        end
        ST_ZS_FIN: begin
          if (slack_q + crm_q < VW'(cexec_q)) begin
            crm_q <= crm_q + slack_q;
          end else begin
            crm_q <= VW'(cexec_q);
            z_q   <= cp64;
          end
          state_q <= ST_OUT_CHECK;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {7'd0, crm_q[TW-1:0], z_q[TW-1:0], cp64 >= resp_q};
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_term_start_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_start |-> state_q == ST_CLS)
    else $error("term unit started outside a table scan");

  a_budget_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_CHECK) |-> crm_q <= VW'(cexec_q))
    else $error("granted budget exceeds execution time");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done step");

  a_wait_has_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_done |-> state_q == ST_WAIT)
    else $error("term result arrived while not waiting");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the mixed-criticality admission test block
// Drives write, clear and admit items on the input stream and predicts each
// admission verdict with a local zero-slack model kept in step with the
// reserve table. It checks every result item field by field and varies the
// idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS      = mcat_pkg::DEF_TABLE_SLOTS;
  localparam int unsigned WDOG_LIMIT = 500_000_000;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // interference groups: priority (higher/lower) by criticality relation
  typedef enum int {GRP_HPHC, GRP_LPHC, GRP_HPSC, GRP_HPLC} grp_e;

  typedef struct {
    logic [1:0]                  action;
    logic [3:0]                  slot;
    logic                        self_skip;
    logic [mcat_pkg::TIME_W-1:0] period;
    logic [mcat_pkg::TIME_W-1:0] exectime;
    logic [mcat_pkg::TIME_W-1:0] nominal;
    logic [mcat_pkg::TIME_W-1:0] rm_exec;
    logic [mcat_pkg::CRIT_W-1:0] crit;
  } req_t;

  // low bit first on the result bus: admitted, then Z, then budget
  typedef struct packed {
    logic [mcat_pkg::TIME_W-1:0] budget;
    logic [mcat_pkg::TIME_W-1:0] zs_instant;
    logic                        admitted;
  } verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = ACT_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  // local copy of the reserve table
  bit              rsv_valid [SLOTS];
  longint unsigned rsv_period [SLOTS];
  longint unsigned rsv_exec [SLOTS];
  longint unsigned rsv_nominal [SLOTS];
  longint unsigned rsv_rm [SLOTS];
  longint unsigned rsv_level [SLOTS];

  // candidate under analysis
  longint unsigned cand_period, cand_exec, cand_crit, cand_rm, cand_skip;
  bit              cand_skip_en;

  verdict_t exp_verdicts[$];
  int       errors = 0;
  bit       src_idle_on = 1'b0;
  bit       sink_idle_on = 1'b0;
  int       sink_hold = 0;
  int       quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  mixed_criticality_admission_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned ceil_div(longint unsigned x, longint unsigned p);
    if (p == 0) p = 1;
    return x / p + ((x % p) != 0 ? 64'd1 : 64'd0);
  endfunction

  function automatic bit in_group(grp_e g, int i);
    bit hp;
    if (!rsv_valid[i]) return 1'b0;
    if (cand_skip_en && i == cand_skip) return 1'b0;
    hp = cand_period >= rsv_period[i];
    case (g)
      GRP_HPHC: return hp && cand_crit < rsv_level[i];
      GRP_LPHC: return !hp && cand_crit < rsv_level[i];
      GRP_HPSC: return hp && cand_crit == rsv_level[i];
      default:  return hp && cand_crit > rsv_level[i];
    endcase
  endfunction

  // critical-mode response time of the candidate; iteration bound means reject
  function automatic longint unsigned crit_response();
    longint unsigned base, resp, prev;
    bit first;
    int rounds;
    base = cand_exec - cand_rm;
    resp = base;
    prev = 0;
    first = 1'b1;
    rounds = 0;
    while (first || (resp > prev && resp <= cand_period)) begin
      if (rounds >= mcat_pkg::ITER_LIMIT) return cand_period + 1;
      rounds++;
      first = 1'b0;
      prev = resp;
      resp = base;
      for (int i = 0; i < SLOTS; i++) begin
        if (in_group(GRP_HPHC, i))
          resp += ceil_div(prev, rsv_period[i]) * rsv_nominal[i];
        else if (in_group(GRP_LPHC, i))
          resp += ceil_div(prev, rsv_period[i]) * (rsv_nominal[i] - rsv_rm[i]);
        else if (in_group(GRP_HPSC, i))
          resp += ceil_div(prev, rsv_period[i]) * rsv_exec[i];
      end
    end
    return resp;
  endfunction

  function automatic longint unsigned rm_load(longint unsigned z);
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (in_group(GRP_HPHC, i))
        acc += ceil_div(z, rsv_period[i]) * rsv_nominal[i];
      else if (in_group(GRP_HPLC, i) || in_group(GRP_HPSC, i))
        acc += ceil_div(z, rsv_period[i]) * rsv_exec[i];
    end
    return acc;
  endfunction

  // apply one accepted item to the table; queue a verdict for admit items
  function automatic void predict_admission(req_t r);
    longint unsigned resp, z, prev_z, interf, slack, push, load1;
    int rounds;
    verdict_t v;
    if (r.action == mcat_pkg::ACT_WRITE) begin
      rsv_valid[r.slot]   = 1'b1;
      rsv_period[r.slot]  = 64'(r.period);
      rsv_exec[r.slot]    = 64'(r.exectime);
      rsv_nominal[r.slot] = 64'(r.nominal);
      rsv_rm[r.slot]      = 64'(r.rm_exec);
      rsv_level[r.slot]   = 64'(r.crit);
      return;
    end
    if (r.action == mcat_pkg::ACT_CLEAR) begin
      rsv_valid[r.slot] = 1'b0;
      return;
    end
    if (r.action != mcat_pkg::ACT_ADMIT) return;
    cand_period  = 64'(r.period);
    cand_exec    = 64'(r.exectime);
    cand_crit    = 64'(r.crit);
    cand_rm      = 0;  // candidate's own budget field is ignored
    cand_skip    = 64'(r.slot);
    cand_skip_en = r.self_skip;
    resp = 0;
    z = 1;
    prev_z = 0;
    rounds = 0;
    while (cand_period >= resp && z > prev_z && rounds < mcat_pkg::ITER_LIMIT) begin
      rounds++;
      prev_z = z;
      resp = crit_response();
      if (cand_period >= resp) begin
        z = cand_period - resp;
        interf = rm_load(z);
        slack = 0;
        if (z > interf + cand_rm) begin
          slack = z - interf - cand_rm;
        end else if (z == interf + cand_rm) begin
          // stalled search: push Z forward, add nothing unless slack opens
          push = resp - cand_exec + cand_rm;
          if (z + push <= cand_period) begin
            load1 = rm_load(z + push);
            if (load1 <= push) begin
              z = z + push;
              slack = z - load1 - cand_rm;
            end
          end
        end
        if (slack + cand_rm < cand_exec) begin
          cand_rm += slack;
        end else begin
          cand_rm = cand_exec;
          z = cand_period;
        end
      end
    end
    v.admitted   = cand_period >= resp;
    v.zs_instant = z[mcat_pkg::TIME_W-1:0];
    v.budget     = cand_rm[mcat_pkg::TIME_W-1:0];
    exp_verdicts.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call, random idle cycles first
  // ---------------------------------------------------------------------------
  task automatic send_item(req_t r);
    @(negedge clk_i);
    while (src_idle_on && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {3'b000, r.crit, r.rm_exec, r.nominal, r.exectime, r.period,
                      r.self_skip, r.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_admission(r);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (exp_verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [1:0] act, int slot, int skip, longint unsigned per,
                              longint unsigned ex, longint unsigned nom,
                              longint unsigned rm, int crit);
    req_t r;
    r.action = act;
    r.slot = 4'(slot);
    r.self_skip = (skip != 0);
    r.period = mcat_pkg::TIME_W'(per);
    r.exectime = mcat_pkg::TIME_W'(ex);
    r.nominal = mcat_pkg::TIME_W'(nom);
    r.rm_exec = mcat_pkg::TIME_W'(rm);
    r.crit = mcat_pkg::CRIT_W'(crit);
    return r;
  endfunction

  // mostly small times so admissions settle quickly, a few wide ones
  function automatic longint unsigned rnd_time();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 64'($urandom_range(1, 3000));
    if (sel < 9) return 64'($urandom_range(1, 1_000_000));
    return ({$urandom, $urandom} & MASK48) | 64'd1;
  endfunction

  function automatic req_t rnd_req();
    req_t r;
    int sel;
    longint unsigned per;
    sel = $urandom_range(0, 99);
    per = rnd_time();
    r = mk(mcat_pkg::ACT_ADMIT, $urandom_range(0, 5), $urandom_range(0, 1), per,
           $urandom_range(0, 3) == 0 ? rnd_time() : per / $urandom_range(2, 12),
           per / $urandom_range(4, 30), per / $urandom_range(8, 60),
           $urandom_range(0, 7));
    if (sel < 3) r.crit = mcat_pkg::CRIT_W'($urandom_range(0, 255));
    if (sel < 40) r.action = mcat_pkg::ACT_WRITE;
    else if (sel < 55) r.action = mcat_pkg::ACT_CLEAR;
    else if (sel < 58) r.action = ACT_NONE;
    if (r.action != mcat_pkg::ACT_ADMIT && $urandom_range(0, 9) == 0)
      r.slot = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_table();
    send_item(mk(mcat_pkg::ACT_ADMIT, 0, 0, 1000, 100, 0, 0, 5));
    send_item(mk(mcat_pkg::ACT_ADMIT, 15, 1, MASK48, MASK48, MASK48, MASK48, 255));
    send_item(mk(mcat_pkg::ACT_ADMIT, 3, 0, 1, 0, 0, 0, 0));
  endtask

  task automatic test_field_extremes();
    // full-width entry, seen as lower priority by a short candidate
    send_item(mk(mcat_pkg::ACT_WRITE, 15, 0, MASK48, MASK48, MASK48, MASK48, 255));
    send_item(mk(mcat_pkg::ACT_ADMIT, 7, 0, 1000, 200, 0, 0, 0));
    send_item(mk(mcat_pkg::ACT_ADMIT, 15, 1, MASK48, 5000, 0, 0, 255));
    send_item(mk(mcat_pkg::ACT_CLEAR, 15, 0, 1, 0, 0, 0, 0));
  endtask

  task automatic test_criticality_groups();
    send_item(mk(mcat_pkg::ACT_WRITE, 0, 0, 100, 20, 10, 5, 10));
    send_item(mk(mcat_pkg::ACT_WRITE, 1, 0, 50, 5, 3, 1, 3));
    send_item(mk(mcat_pkg::ACT_WRITE, 2, 0, 2000, 60, 40, 10, 20));
    send_item(mk(mcat_pkg::ACT_WRITE, 3, 0, 200, 15, 8, 4, 5));
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 400, 60, 0, 0, 5));
    send_item(mk(mcat_pkg::ACT_ADMIT, 3, 1, 400, 60, 0, 0, 5));   // self skip
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 400, 0, 0, 0, 5));    // zero execution time
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 100, 90, 0, 0, 5));   // overload, reject
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 300, 100, 0, 77, 0)); // candidate budget ignored
    send_item(mk(ACT_NONE, 2, 1, 400, 60, 0, 0, 5));              // unused action
    send_item(mk(mcat_pkg::ACT_CLEAR, 1, 0, 1, 0, 0, 0, 0));
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 400, 60, 0, 0, 5));
  endtask

  task automatic test_backpressure();
    // hold the result side while admits pile up behind the held result
    sink_hold = 400_000;
    for (int k = 0; k < 6; k++) send_item(rnd_req());
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 500, 50, 0, 0, 3));
    send_item(mk(mcat_pkg::ACT_ADMIT, 4, 0, 600, 70, 0, 0, 4));
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      src_idle_on  = k >= 30;
      sink_idle_on = k >= 30;
      send_item(rnd_req());
      if (k == 70) wait_drained();  // sender pause until all results are back
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready when enabled, long hold when asked
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_idle_on && $urandom_range(0, 99) < 34);
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[96:0];
      if (exp_verdicts.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        errors++;
      end else begin
        want = exp_verdicts.pop_front();
        if (got.admitted !== want.admitted) begin
          $display("%0t: admitted exp %0d act %0d", $time, want.admitted, got.admitted);
          errors++;
        end
        if (got.zs_instant !== want.zs_instant) begin
          $display("%0t: zero_slack_instant exp %0d act %0d", $time, want.zs_instant,
                   got.zs_instant);
          errors++;
        end
        if (got.budget !== want.budget) begin
          $display("%0t: rm_budget_ns exp %0d act %0d", $time, want.budget, got.budget);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted item on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_field_extremes();
    test_criticality_groups();
    test_backpressure();
    test_random(115);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && exp_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
